// ===== hw/rtl/ray_box_slab_intersect_core_defines.svh =====
//------------------------------------------------------------------------------
// Ray/box slab intersect - assertion macros
// Shared macros for concurrent checks on the ray/box core.
//------------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH

// check that is off while reset is high
`define RBSI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define RBSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rbsi_pkg.sv =====
//------------------------------------------------------------------------------
// Ray/box slab intersect - package
// Fixed constants and pipeline control type.
//------------------------------------------------------------------------------
package rbsi_pkg;

   localparam int NUM_AXES  = 3;
   localparam int IN_FIELDS = 12;

   typedef struct packed {
      logic advance;
   } pipe_ctl_type;

endpackage

// ===== hw/rtl/rbsi_recip_pipe.sv =====
//------------------------------------------------------------------------------
// Ray/box slab intersect - reciprocal pipeline
// Restoring division of 2^(QUOT_BITS-1) by a magnitude, one quotient bit per
// register stage.
//------------------------------------------------------------------------------
module rbsi_recip_pipe #(
   parameter int COORD_WIDTH = 32,
   parameter int QUOT_BITS   = 33
) (
   input  logic                       clock,
   input  rbsi_pkg::pipe_ctl_type     ctl,
   input  logic [COORD_WIDTH-1:0]     dm_in,
   output logic [QUOT_BITS-1:0]       q_out
);
   import rbsi_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int N = QUOT_BITS;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] rem_in [N];
   logic [W-1:0] dm_ff  [N];
   logic [W-1:0] dm_in_s [N];
   logic [N-1:0] q_ff   [N];
   logic [N-1:0] q_in   [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [W-1:0] prev_rem;
      logic [N-1:0] prev_q;
      logic [W:0]   r2;
      if (k == 0) begin : g_first
         // numerator is a single one bit at the top
         assign prev_rem   = '0;
         assign prev_q     = '0;
         assign dm_in_s[k] = dm_in;
         assign r2         = {prev_rem, 1'b1};
      end else begin : g_next
         assign prev_rem   = rem_ff[k-1];
         assign prev_q     = q_ff[k-1];
         assign dm_in_s[k] = dm_ff[k-1];
         assign r2         = {prev_rem, 1'b0};
      end

      always_comb begin
         if (r2 >= {1'b0, dm_in_s[k]}) begin
            rem_in[k] = W'(r2 - {1'b0, dm_in_s[k]});
            q_in[k]   = {prev_q[N-2:0], 1'b1};
         end else begin
            rem_in[k] = r2[W-1:0];
            q_in[k]   = {prev_q[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            dm_ff[k]  <= dm_in_s[k];
         end
      end
   end

   assign q_out = q_ff[N-1];

endmodule

// ===== hw/rtl/ray_box_slab_intersect_core.sv =====
// Throughput: one ray/box test per cycle unless the output stalls; the reciprocal divider
// is pipelined one quotient bit per stage, the products split into partial products over two stages.
// The whole pipe stalls only while a result waits at the output.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.
//------------------------------------------------------------------------------
// Ray/box slab intersect - top level
// Fixed-point slab test of one ray against one axis-aligned box per beat.
//------------------------------------------------------------------------------
module ray_box_slab_intersect_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // origin x,y,z, dir x,y,z, box_min x,y,z, box_max x,y,z (low to high)
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, t_near, t_far (low to high), zero padded
   output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   import rbsi_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int N      = 2*FRAC_BITS + 1;
   localparam int CW     = (N > W) ? N : W;
   localparam int L      = (W + 1) / 2;
   localparam int PW     = 2*W;
   localparam int NSTG   = N + 6;
   localparam int OUT_W  = ((2*W+1+7)/8)*8;

   typedef struct packed {
      logic [W-1:0] lo_mag;
      logic         lo_neg;
      logic [W-1:0] hi_mag;
      logic         hi_neg;
      logic [W-1:0] dm;
      logic         dneg;
      logic         dzero;
   } side_type;

   typedef struct packed {
      logic [W-1:0] lo_mag;
      logic [W-1:0] hi_mag;
      logic [W-1:0] imag;
      logic         lo_neg;
      logic         hi_neg;
      logic         ineg;
   } mul_type;

   typedef struct packed {
      logic [2*L-1:0] ll;
      logic [2*L-1:0] lh;
      logic [2*L-1:0] hl;
      logic [2*L-1:0] hh;
   } pp_type;

   function automatic logic [W-1:0] lim_of(logic neg);
      lim_of = {neg, {(W-1){~neg}}};
   endfunction

   function automatic logic [W-1:0] sat_sub(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] r;
      r = {a[W-1], a} - {b[W-1], b};
      if (r[W] != r[W-1]) sat_sub = lim_of(r[W]);
      else                sat_sub = r[W-1:0];
   endfunction

   function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
      mag_of = v[W-1] ? W'(~v + 1'b1) : v;
   endfunction

   function automatic pp_type part_mul(logic [W-1:0] a, logic [W-1:0] b);
      pp_type p;
      p.ll = a[L-1:0] * b[L-1:0];
      p.lh = a[L-1:0] * b[W-1:L];
      p.hl = a[W-1:L] * b[L-1:0];
      p.hh = a[W-1:L] * b[W-1:L];
      part_mul = p;
   endfunction

   function automatic logic [W-1:0] fin_mul(pp_type p, logic neg);
      logic [PW-1:0] prod;
      logic [PW-1:0] sh;
      logic [W-1:0]  lim;
      logic [W-1:0]  m;
      prod = (PW'(p.hh) << (2*L)) + ((PW'(p.lh) + PW'(p.hl)) << L) + PW'(p.ll);
      sh   = prod >> FRAC_BITS;
      lim  = lim_of(neg);
      m    = (sh > PW'(lim)) ? lim : sh[W-1:0];
      fin_mul = neg ? W'(~m + 1'b1) : m;
   endfunction

   pipe_ctl_type ctl;
   logic         adv;
   logic [NSTG-1:0] vld_ff;

   logic [W-1:0] org_ff  [NUM_AXES];
   logic [W-1:0] dir_ff  [NUM_AXES];
   logic [W-1:0] bmin_ff [NUM_AXES];
   logic [W-1:0] bmax_ff [NUM_AXES];

   side_type side_ff [N+1][NUM_AXES];
   side_type side_in [NUM_AXES];
   logic [N-1:0] q_div [NUM_AXES];

   mul_type mul_ff [NUM_AXES];
   mul_type mul_in [NUM_AXES];
   pp_type  pp_lo_ff [NUM_AXES];
   pp_type  pp_hi_ff [NUM_AXES];
   logic    pneg_lo_ff [NUM_AXES];
   logic    pneg_hi_ff [NUM_AXES];
   logic    ineg2_ff [NUM_AXES];

   logic signed [W-1:0] tn_ff [NUM_AXES];
   logic signed [W-1:0] tf_ff [NUM_AXES];
   logic signed [W-1:0] tn_in [NUM_AXES];
   logic signed [W-1:0] tf_in [NUM_AXES];

   logic signed [W-1:0] c_tn_ff, c_tf_ff, c_zn_ff, c_zf_ff;
   logic signed [W-1:0] c_tn_in, c_tf_in;
   logic                c_dis_ff, c_dis_in;

   logic                out_vld_ff;
   logic                out_hit_ff, out_hit_in;
   logic [W-1:0]        out_near_ff, out_near_in;
   logic [W-1:0]        out_far_ff, out_far_in;
   logic signed [W-1:0] fin_tn, fin_tf;

   // single stall point: output register full and not taken
   assign adv         = !out_vld_ff || rsp_tready;
   assign ctl.advance = adv;
   assign req_tready  = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NSTG-2:0], req_tvalid};
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            org_ff[a]  <= req_tdata[a*W +: W];
            dir_ff[a]  <= req_tdata[(a+3)*W +: W];
            bmin_ff[a] <= req_tdata[(a+6)*W +: W];
            bmax_ff[a] <= req_tdata[(a+9)*W +: W];
         end
      end
   end

   // differences, magnitudes
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic [W-1:0] dlo, dhi;
         dlo = sat_sub(bmin_ff[a], org_ff[a]);
         dhi = sat_sub(bmax_ff[a], org_ff[a]);
         side_in[a].lo_mag = mag_of(dlo);
         side_in[a].lo_neg = dlo[W-1];
         side_in[a].hi_mag = mag_of(dhi);
         side_in[a].hi_neg = dhi[W-1];
         side_in[a].dm     = mag_of(dir_ff[a]);
         side_in[a].dneg   = dir_ff[a][W-1];
         side_in[a].dzero  = (dir_ff[a] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= N; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      rbsi_recip_pipe #(
         .COORD_WIDTH (W),
         .QUOT_BITS   (N)
      ) u_recip (
         .clock (clock),
         .ctl   (ctl),
         .dm_in (side_ff[0][a].dm),
         .q_out (q_div[a])
      );
   end

   // reciprocal saturation; zero direction reads as the largest positive value
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic [W-1:0]  lim;
         logic [CW-1:0] q_ext;
         side_type      sd;
         sd    = side_ff[N][a];
         lim   = lim_of(sd.dneg);
         q_ext = CW'(q_div[a]);
         mul_in[a].lo_mag = sd.lo_mag;
         mul_in[a].hi_mag = sd.hi_mag;
         mul_in[a].lo_neg = sd.lo_neg;
         mul_in[a].hi_neg = sd.hi_neg;
         if (sd.dzero) begin
            mul_in[a].imag = lim_of(1'b0);
            mul_in[a].ineg = 1'b0;
         end else begin
            mul_in[a].imag = (q_ext > CW'(lim)) ? lim : q_ext[W-1:0];
            mul_in[a].ineg = sd.dneg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff <= mul_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            pp_lo_ff[a]   <= part_mul(mul_ff[a].lo_mag, mul_ff[a].imag);
            pp_hi_ff[a]   <= part_mul(mul_ff[a].hi_mag, mul_ff[a].imag);
            pneg_lo_ff[a] <= mul_ff[a].lo_neg ^ mul_ff[a].ineg;
            pneg_hi_ff[a] <= mul_ff[a].hi_neg ^ mul_ff[a].ineg;
            ineg2_ff[a]   <= mul_ff[a].ineg;
         end
      end
   end

   // sum partial products, saturate, order entry/exit
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic [W-1:0] ta, tb;
         ta = fin_mul(pp_lo_ff[a], pneg_lo_ff[a]);
         tb = fin_mul(pp_hi_ff[a], pneg_hi_ff[a]);
         tn_in[a] = ineg2_ff[a] ? tb : ta;
         tf_in[a] = ineg2_ff[a] ? ta : tb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tn_ff <= tn_in;
         tf_ff <= tf_in;
      end
   end

   // fold x with y; z disjointness is tested against x alone
   always_comb begin
      c_dis_in = (tn_ff[0] > tf_ff[1]) || (tn_ff[1] > tf_ff[0]) ||
                 (tn_ff[0] > tf_ff[2]) || (tn_ff[2] > tf_ff[0]);
      c_tn_in  = (tn_ff[1] > tn_ff[0]) ? tn_ff[1] : tn_ff[0];
      c_tf_in  = (tf_ff[1] < tf_ff[0]) ? tf_ff[1] : tf_ff[0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_dis_ff <= c_dis_in;
         c_tn_ff  <= c_tn_in;
         c_tf_ff  <= c_tf_in;
         c_zn_ff  <= tn_ff[2];
         c_zf_ff  <= tf_ff[2];
      end
   end

   always_comb begin
      fin_tn      = (c_zn_ff > c_tn_ff) ? c_zn_ff : c_tn_ff;
      fin_tf      = (c_zf_ff < c_tf_ff) ? c_zf_ff : c_tf_ff;
      out_hit_in  = !c_dis_ff && (fin_tn < fin_tf) && !fin_tf[W-1];
      out_near_in = out_hit_in ? fin_tn : '0;
      out_far_in  = out_hit_in ? fin_tf : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff  <= out_hit_in;
         out_near_ff <= out_near_in;
         out_far_ff  <= out_far_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OUT_W'({out_far_ff, out_near_ff, out_hit_ff});

endmodule

// ===== hw/rtl/rbsi_checker.sv =====
//------------------------------------------------------------------------------
// Ray/box slab intersect - port checker
// Concurrent checks on the top level's result channel and its input stall.
//------------------------------------------------------------------------------
`include "ray_box_slab_intersect_core_defines.svh"

module rbsi_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   import rbsi_pkg::*;

   localparam int W = COORD_WIDTH;

   logic signed [W-1:0] near_s, far_s;
   assign near_s = rsp_tdata[W:1];
   assign far_s  = rsp_tdata[2*W:W+1];

   `RBSI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `RBSI_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled beat changed")
   `RBSI_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> near_s == 0 && far_s == 0, "miss with nonzero distances")
   `RBSI_ASSERT(a_hit_order, clock, reset, rsp_tvalid && rsp_tdata[0] |-> near_s < far_s && !far_s[W-1], "hit with bad interval")
   `RBSI_ASSERT(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken while output stalled")

endmodule

bind ray_box_slab_intersect_core rbsi_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_rbsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
